// File: rtl/gssf_pkg.sv
package gssf_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int NUM_HEADERS     = 11;
  localparam int PREFIX_LEN      = 9;
  localparam int HDR_ID_W        = 4;
  localparam int FLEN_W          = 11;
  localparam int RIDX_W          = 10;

  localparam logic [NUM_HEADERS-1:0] ENABLE_RESET = 11'd63;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_t;

  // position 0 is the first byte of the frame
  typedef logic [0:PREFIX_LEN-1][7:0] prefix_t;

  // header text padded with spaces; only the first HDR_LEN bytes count
  localparam prefix_t HDR_TEXT [NUM_HEADERS] = '{
    "$GNRMC   ", "#AGRICA  ", "#BESTPOSA", "#BESTVELA", "$GNTRA   ",
    "$GPTRA   ", "$GNGGA   ", "$GNVTG   ", "$GNZDA   ", "$GPZDA   ",
    "#HEADINGA"
  };

  localparam logic [3:0] HDR_LEN [NUM_HEADERS] = '{
    4'd6, 4'd7, 4'd9, 4'd9, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd9
  };

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        data_byte;
    logic [RIDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic              frame_done;
    logic [HDR_ID_W-1:0] header_id;
    logic [FLEN_W-1:0] frame_length;
    logic [7:0]        read_byte;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [HDR_ID_W-1:0] id;
  } hdr_match_t;

endpackage

// File: rtl/gssf_ram.sv
module gssf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/gssf_hdr_match.sv
module gssf_hdr_match
  import gssf_pkg::*;
#(
  parameter int FILL_W = 11
) (
  input  prefix_t                 prefix,
  input  logic [FILL_W-1:0]       fill,
  input  logic [NUM_HEADERS-1:0]  enable,
  output hdr_match_t              match
);

  // fill is the length before the closing LF; the LF itself never equals a
  // header character, so the header must fit entirely in the bytes before it
  always_comb begin
    logic ok;
    match = '0;
    for (int h = NUM_HEADERS - 1; h >= 0; h--) begin
      ok = enable[h] && (fill >= FILL_W'(HDR_LEN[h]));
      for (int i = 0; i < PREFIX_LEN; i++) begin
        if ((i < int'(HDR_LEN[h])) && (prefix[i] != HDR_TEXT[h][i])) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        match.hit = 1'b1;
        match.id  = HDR_ID_W'(h);
      end
    end
  end

endmodule

// File: rtl/gnss_sentence_framer_filter_top.sv
// Channel  Signals                          Dir  Carries
// -------  -------------------------------  ---  -------------------------------------
// in       in_valid / in_ready / in_data    in   push, read or flush request
// out      out_valid / out_ready / out_data out  one result per input request
// cfg      cfg_valid / cfg_ready / cfg_data in   header_enable write (always ready)
//
// One request per cycle while results are taken: each accepted request is finished at its accept edge
// and its result sits in the output register on the next cycle.
// in_ready is high while the output register is empty or being drained, so a
// stalled consumer holds back only new requests, never a waiting result.
// Read data comes from the frame store's registered port; the read data
// register is loaded only when a read request is accepted, so it holds during
// output stalls. Reset (rst, synchronous) empties the frame, sets
// header_enable to 63 and drops out_valid; the frame store is not cleared.
module gnss_sentence_framer_filter_top
  import gssf_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [NUM_HEADERS-1:0] cfg_data
);

  localparam int FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // frame state
  logic [FILL_W-1:0]      fill;
  logic [FILL_W-1:0]      fill_next;
  prefix_t                prefix;
  prefix_t                prefix_next;
  logic [7:0]             last_byte;
  logic [7:0]             last_byte_next;
  logic [NUM_HEADERS-1:0] header_enable;

  // result register
  logic                   res_done;
  logic [HDR_ID_W-1:0]    res_id;
  logic [FLEN_W-1:0]      res_flen;
  logic                   res_ovf;
  logic                   res_rd;

  logic                   done_next;
  logic [HDR_ID_W-1:0]    id_next;
  logic [FLEN_W-1:0]      flen_next;
  logic                   ovf_next;
  logic                   rd_next;

  // frame store ports
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   rd_en;
  logic [7:0]             rd_data;

  logic                   accept;
  logic                   room;
  hdr_match_t             match;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign room      = fill < FILL_W'(STORE_DEPTH);

  gssf_hdr_match #(
    .FILL_W (FILL_W)
  ) u_hdr_match (
    .prefix (prefix),
    .fill   (fill),
    .enable (header_enable),
    .match  (match)
  );

  gssf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_data.data_byte),
    .re    (rd_en),
    .raddr (ADDR_W'(in_data.read_index)),
    .rdata (rd_data)
  );

  always_comb begin
    logic put;
    logic [FILL_W-1:0] pos;
    put            = 1'b0;
    pos            = fill;
    fill_next      = fill;
    prefix_next    = prefix;
    last_byte_next = last_byte;
    done_next      = 1'b0;
    id_next        = '0;
    flen_next      = '0;
    ovf_next       = 1'b0;
    rd_next        = 1'b0;
    rd_en          = 1'b0;

    case (in_data.mode)
      MODE_PUSH: begin
        if (in_data.data_byte == CH_DOLLAR || in_data.data_byte == CH_HASH) begin
          // start of sentence: restart the frame at position 0
          prefix_next = '0;
          pos         = '0;
          put         = 1'b1;
        end else if (in_data.data_byte == CH_LF) begin
          // LF counts only right after a CR; it closes the frame only on an enabled header
          if (fill != '0 && last_byte == CH_CR) begin
            if (!room) begin
              ovf_next = 1'b1;
            end else begin
              put = 1'b1;
            end
          end
        end else if (!room) begin
          ovf_next = 1'b1;
        end else begin
          put = 1'b1;
        end
      end
      MODE_READ: begin
        rd_en   = accept;
        rd_next = 32'(in_data.read_index) < STORE_DEPTH;
      end
      MODE_FLUSH: begin
        fill_next      = '0;
        last_byte_next = '0;
        prefix_next    = '0;
      end
      default: begin
      end
    endcase

    if (put) begin
      if (pos < FILL_W'(PREFIX_LEN)) begin
        prefix_next[pos[3:0]] = in_data.data_byte;
      end
      fill_next      = pos + 1'b1;
      last_byte_next = in_data.data_byte;
      // closing LF on an enabled header: report and empty the frame
      if (in_data.data_byte == CH_LF && match.hit) begin
        done_next = 1'b1;
        id_next   = match.id;
        flen_next = FLEN_W'(fill + 1'b1);
        fill_next = '0;
      end
    end

    wr_en   = accept && put;
    wr_addr = ADDR_W'(pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      prefix        <= '0;
      last_byte     <= '0;
      header_enable <= ENABLE_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        header_enable <= cfg_data;
      end
      if (accept) begin
        fill      <= fill_next;
        prefix    <= prefix_next;
        last_byte <= last_byte_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_done <= done_next;
      res_id   <= id_next;
      res_flen <= flen_next;
      res_ovf  <= ovf_next;
      res_rd   <= rd_next;
    end
  end

  always_comb begin
    out_data.frame_done   = res_done;
    out_data.header_id    = res_id;
    out_data.frame_length = res_flen;
    out_data.read_byte    = res_rd ? rd_data : 8'd0;
    out_data.overflow     = res_ovf;
  end

endmodule

// File: sim/gssf_frame_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and header_enable channels, keeps its own copy of
// the framer state and compares every result with the oldest expected one.
module gssf_frame_checker
  import gssf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [NUM_HEADERS-1:0] cfg_data,
  output int unsigned            pending,
  output int unsigned            written_span,
  output int unsigned            errors
);

  logic [7:0]             store_img [STORE_DEPTH_DEF];
  logic [7:0]             lead [PREFIX_LEN];
  logic [7:0]             newest;
  logic [NUM_HEADERS-1:0] enables;
  int unsigned            held;
  int unsigned            span;
  int unsigned            bad;
  out_item_t              awaited [$];

  // sentence tags, left aligned, blank padded
  function automatic logic [71:0] tag_text(input int id);
    case (id)
      0:       return "$GNRMC   ";
      1:       return "#AGRICA  ";
      2:       return "#BESTPOSA";
      3:       return "#BESTVELA";
      4:       return "$GNTRA   ";
      5:       return "$GPTRA   ";
      6:       return "$GNGGA   ";
      7:       return "$GNVTG   ";
      8:       return "$GNZDA   ";
      9:       return "$GPZDA   ";
      default: return "#HEADINGA";
    endcase
  endfunction

  function automatic int tag_len(input int id);
    case (id)
      1:          return 7;
      2, 3, 10:   return 9;
      default:    return 6;
    endcase
  endfunction

  function automatic bit tag_seen(input int id);
    logic [71:0] text;
    text = tag_text(id);
    if (held < tag_len(id)) return 1'b0;
    for (int i = 0; i < tag_len(id); i++)
      if (lead[i] != text[71-8*i -: 8]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic clear_lead();
    for (int i = 0; i < PREFIX_LEN; i++) lead[i] = 8'h00;
  endtask

  task automatic stash(input logic [7:0] b);
    if (held < STORE_DEPTH_DEF) begin
      store_img[held] = b;
      if (held < PREFIX_LEN) lead[held] = b;
      held++;
      newest = b;
      if (held > span) span = held;
    end
  endtask

  task automatic frame_step(input in_item_t req, output out_item_t res);
    logic [7:0] b;
    bit         found;
    res   = '0;
    b     = req.data_byte;
    found = 1'b0;
    case (req.mode)
      MODE_PUSH: begin
        if (b == CH_DOLLAR || b == CH_HASH) begin
          held = 0;
          clear_lead();
          stash(b);
        end else if (b == CH_LF) begin
          if (held != 0 && newest == CH_CR) begin
            if (held >= STORE_DEPTH_DEF) begin
              res.overflow = 1'b1;
            end else begin
              stash(b);
              for (int h = 0; h < NUM_HEADERS; h++) begin
                if (!found && enables[h] && tag_seen(h)) begin
                  found            = 1'b1;
                  res.frame_done   = 1'b1;
                  res.header_id    = HDR_ID_W'(h);
                  res.frame_length = FLEN_W'(held);
                end
              end
              if (found) held = 0;
            end
          end
        end else if (held >= STORE_DEPTH_DEF) begin
          res.overflow = 1'b1;
        end else begin
          stash(b);
        end
      end
      MODE_READ: begin
        res.read_byte = store_img[req.read_index];
      end
      MODE_FLUSH: begin
        held   = 0;
        newest = 8'h00;
        clear_lead();
      end
      default: ;
    endcase
  endtask

  task automatic field_check(input string what, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      $display("%0t gssf_frame_checker: %s expected %0d got %0d", $time, what, want, got);
      bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst) begin
      held    = 0;
      newest  = 8'h00;
      enables = ENABLE_RESET;
      span    = 0;
      clear_lead();
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (awaited.size() == 0) begin
          $display("%0t gssf_frame_checker: result %h with nothing expected", $time, got);
          bad++;
        end else begin
          want = awaited.pop_front();
          field_check("frame_done", want.frame_done, got.frame_done);
          field_check("header_id", want.header_id, got.header_id);
          field_check("frame_length", want.frame_length, got.frame_length);
          field_check("read_byte", want.read_byte, got.read_byte);
          field_check("overflow", want.overflow, got.overflow);
        end
      end
      if (cfg_valid && cfg_ready) enables = cfg_data;
      if (in_valid && in_ready) begin
        frame_step(in_data, want);
        awaited.push_back(want);
      end
    end
    pending      <= awaited.size();
    written_span <= span;
    errors       <= bad;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

// Sentence framer bench. The top only makes requests, drives the result
// back-pressure and writes header_enable; gssf_frame_checker does all the
// predicting and comparing and reports its counts back here.
module tb;
  import gssf_pkg::*;

  // request code the block has no use for; it must answer all zeros
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // ways a random sentence can be spoiled
  localparam int FLAW_NONE     = 0;
  localparam int FLAW_SHORT    = 1;  // header cut short, closed right away
  localparam int FLAW_RESTART  = 2;  // a fresh '$' may land in the body
  localparam int FLAW_NO_CR    = 3;  // bare line feed, sentence stays open
  localparam int FLAW_EXTRA_LF = 4;  // second line feed after the close

  localparam int PHASE_ITEMS = 80;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [NUM_HEADERS-1:0] cfg_data  = '0;

  int unsigned pending;      // results still owed by the block
  int unsigned stored_span;  // store positions written since reset
  int unsigned mismatches;

  int items_sent = 0;
  int quiet_in   = 0;
  int quiet_out  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gnss_sentence_framer_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  gssf_frame_checker frame_watch (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .written_span (stored_span),
    .errors       (mismatches)
  );

  // Wait before the next request or result: mostly a random draw, with now
  // and then a run of back-to-back traffic.
  task automatic pick_wait(inout int quiet, output int w);
    if (quiet > 0) begin
      quiet--;
      w = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 40);
      w     = 0;
    end else begin
      w = $urandom_range(0, 19);
    end
  endtask

  // One request. Returns at the edge that accepts it; valid stays up when the
  // next request follows with no gap, so it is never dropped and raised in
  // the same step.
  task automatic issue(input logic [1:0] mode, input logic [7:0] b,
                       input logic [RIDX_W-1:0] idx);
    in_item_t req;
    int       w;
    req.mode       = mode;
    req.data_byte  = b;
    req.read_index = idx;
    pick_wait(quiet_in, w);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push(input logic [7:0] b);
    issue(MODE_PUSH, b, RIDX_W'($urandom));
  endtask

  // sentence body byte: mostly printable, never a start mark or line feed
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7e));
    end while (c == CH_DOLLAR || c == CH_HASH || c == CH_LF);
    return c;
  endfunction

  // id below NUM_HEADERS sends that known tag, anything else a made-up one
  task automatic send_sentence(input int id, input int body_len, input int flaw);
    int n;
    int cut;
    if (flaw == FLAW_SHORT) body_len = 0;
    if (id < NUM_HEADERS) begin
      n = HDR_LEN[id];
      if (flaw == FLAW_SHORT) n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) push(HDR_TEXT[id][i]);
    end else begin
      push($urandom_range(0, 1) ? CH_DOLLAR : CH_HASH);
      repeat ($urandom_range(2, 8)) push(8'($urandom_range(8'h41, 8'h5a)));
    end
    cut = (flaw == FLAW_RESTART) ? $urandom_range(0, body_len) : -1;
    for (int i = 0; i < body_len; i++) begin
      if (i == cut) push(CH_DOLLAR);
      push(body_char());
    end
    if (flaw != FLAW_NO_CR) push(CH_CR);
    push(CH_LF);
    if (flaw == FLAW_EXTRA_LF) push(CH_LF);
  endtask

  // Mostly whole sentences with random tags and bodies, the rest line noise,
  // reads, flushes, the spare code and stray line ends. Reads only touch
  // positions already written since reset.
  task automatic random_traffic(input int goal);
    int stop;
    int pick;
    stop = items_sent + goal;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_sentence(($urandom_range(0, 4) == 0) ? NUM_HEADERS
                                                  : $urandom_range(0, NUM_HEADERS - 1),
                      ($urandom_range(0, 5) == 0) ? $urandom_range(0, 90)
                                                  : $urandom_range(0, 30),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(FLAW_SHORT, FLAW_EXTRA_LF)
                                                  : FLAW_NONE);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 6)) push(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        if (stored_span != 0) begin
          issue(MODE_READ, 8'($urandom), RIDX_W'($urandom_range(0, stored_span - 1)));
        end else begin
          push(CH_CR);
        end
      end else if (pick < 92) begin
        issue(MODE_FLUSH, 8'($urandom), RIDX_W'($urandom));
      end else if (pick < 95) begin
        issue(MODE_SPARE, 8'($urandom), RIDX_W'($urandom));
      end else begin
        push(CH_CR);
        push(CH_LF);
      end
    end
  endtask

  // drop valid and let every owed result come home, plus a little margin
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_enables(input logic [NUM_HEADERS-1:0] mask);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: a fresh random wait before each result
  initial begin : result_sink
    int w;
    forever begin
      pick_wait(quiet_out, w);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int                     hid;
    logic [NUM_HEADERS-1:0] mask;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, header_enable still at its reset value.
    push(CH_LF);                                  // line feed on an empty store
    for (int i = 0; i < HDR_LEN[0]; i++) push(HDR_TEXT[0][i]);
    push(CH_CR);
    push(CH_LF);                                  // closes the shortest sentence
    issue(MODE_READ, 8'h00, 10'd0);
    issue(MODE_READ, 8'hff, 10'd7);
    push(CH_DOLLAR);
    push("G");
    push("N");
    push(CH_CR);
    push("X");
    push(CH_LF);                                  // not after CR: ignored
    push(CH_CR);
    push(CH_LF);                                  // accepted after CR, but matches no tag, so the frame stays open
    push(8'h00);
    push(8'hff);
    issue(MODE_FLUSH, 8'h5a, 10'h3ff);
    issue(MODE_SPARE, 8'ha5, 10'h155);

    // All tags on. A known sentence fills the store up to its last byte, a CR,
    // so the closing line feed and later bytes drop.
    set_enables({NUM_HEADERS{1'b1}});
    hid = $urandom_range(0, NUM_HEADERS - 1);
    for (int i = 0; i < HDR_LEN[hid]; i++) push(HDR_TEXT[hid][i]);
    repeat (STORE_DEPTH_DEF - 1 - HDR_LEN[hid]) push(body_char());
    push(CH_CR);                                  // store now full, last byte CR
    push(CH_LF);
    push(body_char());
    push(CH_CR);
    random_traffic(PHASE_ITEMS);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       mask = '0;
        1:       mask = NUM_HEADERS'($urandom_range(1, 2046));
        2:       mask = 11'h400;                  // only the heading tag
        3:       mask = 11'h555;
        4:       mask = 11'h2aa;
        default: mask = ENABLE_RESET;
      endcase
      set_enables(mask);
      random_traffic(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// File: gnss_sentence_framer_filter_top.f
rtl/gssf_pkg.sv
rtl/gssf_ram.sv
rtl/gssf_hdr_match.sv
rtl/gnss_sentence_framer_filter_top.sv
sim/gssf_frame_checker.sv
sim/tb.sv
